FILE: hdl/rpa_pkg.sv
`default_nettype none
package rpa_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 15;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_INCREF = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STACKFULL = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_status_t;

endpackage
`default_nettype wire

FILE: hdl/rpa_stack.sv
`default_nettype none
module rpa_stack #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 15
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              pop,
  input  wire logic [DATA_W-1:0] push_data,
  output logic      [DATA_W-1:0] top_data,
  output rpa_pkg::stack_status_t stat
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEPTH_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_dec;

  assign depth_dec  = depth - DEPTH_W'(1);
  assign stat.empty = (depth == '0);
  assign stat.full  = (depth == DEPTH_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (pop) begin
      depth <= depth_dec;
    end else if (push) begin
      depth <= depth + DEPTH_W'(1);
    end
  end

  // read the top entry every cycle; valid the cycle after a pop is issued
  always_ff @(posedge clk) begin
    if (push) begin
      mem[depth[AW-1:0]] <= push_data;
    end
    top_data <= mem[depth_dec[AW-1:0]];
  end

endmodule
`default_nettype wire

FILE: hdl/refcounted_page_allocator_top.sv
// Reference-counted page allocator.
// Input channel (in_valid/in_ready) carries operation and byte_address:
// alloc, free or incref of one page. Output channel (out_valid/out_ready)
// returns one result per input: status, page_address, returned_to_pool
// and count_after. cfg_wr_en/cfg_wr_data set first_usable_page; the user
// must write it only while the block is idle; the block does not enforce this.
// One item at a time: a sequencer walks each operation through the
// free-stack RAM and the reference-count RAM, at most one read-modify-write
// of the count RAM per item, both RAMs with registered read data.
// An alloc served from the free stack passes the states DEC, POP, RD, WR
// and OUT; other alloc, free and incref pass DEC, RD, WR and OUT; a rejected
// item, an alloc with no page left or the no-op code goes from DEC to OUT.
// in_ready rises again the cycle after the output transfer, so a new item
// is taken only after the previous result has been transferred.
// While out_ready is low the result holds and no new item is taken.
// After reset the count RAM is swept to zero, one page per cycle, through
// all NUM_PAGES pages; in_ready stays low during the sweep.
`default_nettype none
module refcounted_page_allocator_top #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rpa_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rpa_pkg::OP_W-1:0]       operation,
  input  wire logic [31:0]                    byte_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [rpa_pkg::STATUS_W-1:0]   status,
  output logic      [31:0]                    page_address,
  output logic                                returned_to_pool,
  output logic      [rpa_pkg::COUNT_W-1:0]    count_after
);

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam logic [63:0] TOP_ADDR = 64'(NUM_PAGES) * 64'(PAGE_BYTES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                    state;
  logic [PAGE_W-1:0]             clr_idx;
  logic [rpa_pkg::CFG_W-1:0]     first_usable;
  logic [DEPTH_W-1:0]            fresh;
  logic [DEPTH_W-1:0]            fresh_dec;
  logic [rpa_pkg::OP_W-1:0]      op_q;
  logic [31:0]                   addr_q;
  logic [PAGE_W-1:0]             page;

  logic [rpa_pkg::COUNT_W-1:0]   counts [NUM_PAGES];
  logic [rpa_pkg::COUNT_W-1:0]   cnt_rd;
  logic                          cnt_we;
  logic [PAGE_W-1:0]             cnt_waddr;
  logic [rpa_pkg::COUNT_W-1:0]   cnt_wdata;
  logic [rpa_pkg::COUNT_W-1:0]   cnt_new;
  logic                          cnt_sat;
  logic                          push_want;

  logic                          stk_push;
  logic                          stk_pop;
  logic [PAGE_W-1:0]             stk_top;
  rpa_pkg::stack_status_t        stk_stat;

  logic [31:0]                   page_full;
  logic                          below_top;
  logic                          aligned;
  logic                          fresh_ok;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  assign fresh_dec = fresh - DEPTH_W'(1);
  assign page_full = addr_q >> OFF_W;
  assign below_top = ({32'd0, addr_q} < TOP_ADDR);
  assign aligned   = (addr_q[OFF_W-1:0] == '0);
  assign fresh_ok  = (32'(fresh) > 32'(first_usable)) && (fresh != '0);
  assign cnt_sat   = (cnt_rd == rpa_pkg::COUNT_MAX);

  always_comb begin
    cnt_new   = cnt_rd;
    push_want = 1'b0;
    unique case (op_q)
      rpa_pkg::OP_ALLOC, rpa_pkg::OP_INCREF: begin
        cnt_new = cnt_sat ? cnt_rd : cnt_rd + rpa_pkg::COUNT_W'(1);
      end
      rpa_pkg::OP_FREE: begin
        cnt_new   = (cnt_rd == '0) ? '0 : cnt_rd - rpa_pkg::COUNT_W'(1);
        push_want = (cnt_new == '0);
      end
      default: begin
        cnt_new = cnt_rd;
      end
    endcase
  end

  assign stk_pop  = (state == S_DEC) && (op_q == rpa_pkg::OP_ALLOC) && !stk_stat.empty;
  assign stk_push = (state == S_WR) && (op_q == rpa_pkg::OP_FREE) && push_want
                    && !stk_stat.full;

  assign cnt_we    = (state == S_CLR) || (state == S_WR);
  assign cnt_waddr = (state == S_CLR) ? clr_idx : page;
  assign cnt_wdata = (state == S_CLR) ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= counts[page];
  end

  rpa_stack #(
    .DEPTH  (NUM_PAGES),
    .DATA_W (PAGE_W)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .push      (stk_push),
    .pop       (stk_pop),
    .push_data (page),
    .top_data  (stk_top),
    .stat      (stk_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= '0;
    end else if (cfg_wr_en) begin
      first_usable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      fresh   <= DEPTH_W'(NUM_PAGES);
    end else begin
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + PAGE_W'(1);
          if (clr_idx == PAGE_W'(NUM_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= operation;
            addr_q <= byte_address;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          page_address     <= '0;
          returned_to_pool <= 1'b0;
          count_after      <= '0;
          unique case (op_q)
            rpa_pkg::OP_ALLOC: begin
              if (!stk_stat.empty) begin
                state <= S_POP;
              end else if (fresh_ok) begin
                fresh <= fresh_dec;
                page  <= fresh_dec[PAGE_W-1:0];
                state <= S_RD;
              end else begin
                status <= rpa_pkg::ST_EMPTY;
                state  <= S_OUT;
              end
            end
            rpa_pkg::OP_FREE: begin
              if (!aligned || !below_top || (page_full < 32'(first_usable))) begin
                status <= rpa_pkg::ST_BADADDR;
                state  <= S_OUT;
              end else begin
                page  <= page_full[PAGE_W-1:0];
                state <= S_RD;
              end
            end
            rpa_pkg::OP_INCREF: begin
              if (!below_top) begin
                status <= rpa_pkg::ST_BADADDR;
                state  <= S_OUT;
              end else begin
                page  <= page_full[PAGE_W-1:0];
                state <= S_RD;
              end
            end
            default: begin
              status <= rpa_pkg::ST_OK;
              state  <= S_OUT;
            end
          endcase
        end
        S_POP: begin
          page  <= stk_top;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          count_after      <= cnt_new;
          returned_to_pool <= stk_push;
          page_address     <= (op_q == rpa_pkg::OP_ALLOC) ? (32'(page) << OFF_W) : '0;
          priority if ((op_q != rpa_pkg::OP_FREE) && cnt_sat) begin
            status <= rpa_pkg::ST_OVERFLOW;
          end else if ((op_q == rpa_pkg::OP_FREE) && push_want && stk_stat.full) begin
            status <= rpa_pkg::ST_STACKFULL;
          end else begin
            status <= rpa_pkg::ST_OK;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
